// File: sv/mrl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrl_pkg;

  localparam int DEPTH     = 16;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);

  localparam logic [CNT_W-1:0] MAX_SIZE_RST = CNT_W'(DEPTH);

  // Command codes
  localparam logic [1:0] CMD_PUT     = 2'd0;
  localparam logic [1:0] CMD_PROMOTE = 2'd1;
  localparam logic [1:0] CMD_LOOK    = 2'd2;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_RANGE    = 2'd1;
  localparam logic [1:0] STAT_NULL_KEY = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_APPLY = 1'b1
  } mrl_state_e;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [KEY_WIDTH-1:0] key;
    logic [IDX_W-1:0]     index;
  } mrl_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 hit;
    logic [IDX_W-1:0]     hit_position;
    logic [KEY_WIDTH-1:0] key_out;
    logic                 evicted;
    logic [KEY_WIDTH-1:0] evicted_key;
    logic [CNT_W-1:0]     count;
  } mrl_res_t;

  typedef struct packed {
    logic capture;
    logic apply;
  } mrl_ctrl_t;

endpackage

`default_nettype wire

// File: sv/mru_recency_list.sv
`timescale 1ns / 1ps
`default_nettype none

// Recency list: each command has an accept cycle (key search) and an apply
// cycle (list shift, result registered). Busy is high during the apply cycle,
// so a new command is taken only once the previous one has been applied.
// result_valid_o pulses for one cycle right after the apply cycle and the
// receiver cannot stall it. Reset empties the list and sets max_size to DEPTH;
// entry storage is not cleared, only the count.
module mru_recency_list (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Command channel: a transaction is taken when start is high and busy low
  input  logic                      start,
  output logic                      busy,
  input  mrl_pkg::mrl_req_t         req_i,
  // Result channel: one transaction per command, marked by the strobe
  output logic                      result_valid_o,
  output mrl_pkg::mrl_res_t         res_o,
  // max_size register write
  input  logic                      cfg_we_i,
  input  logic [mrl_pkg::CNT_W-1:0] cfg_wdata_i
);
  import mrl_pkg::*;

  mrl_ctrl_t ctrl;

  // Sequence capture and apply; own the result strobe.
  mrl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .ctrl_o         (ctrl),
    .result_valid_o (result_valid_o)
  );

  // Hold the list, search it at capture, reorder it and build the result at
  // apply. Only one entry is read through a mux per command: the hit, the
  // indexed entry or the least recent one.
  mrl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// File: sv/mrl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mrl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output mrl_pkg::mrl_ctrl_t ctrl_o,
  output logic             result_valid_o
);
  import mrl_pkg::*;

  mrl_state_e state_q, state_d;
  logic       done_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_APPLY;
      end
      ST_APPLY: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o         = 1'b1;
    ctrl_o.capture = 1'b0;
    ctrl_o.apply   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o         = 1'b0;
        ctrl_o.capture = start_i;
      end
      ST_APPLY: ctrl_o.apply = 1'b1;
      default:  busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ctrl_o.apply;
    end
  end

  assign result_valid_o = done_q;

  a_apply_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.apply |=> !ctrl_o.apply) else $error("apply lasted more than one cycle");
  a_capture_then_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.capture |=> ctrl_o.apply) else $error("capture not followed by apply");
  a_done_after_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.apply |=> result_valid_o && !busy_o) else $error("no result after apply");

endmodule

`default_nettype wire

// File: sv/mrl_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mrl_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mrl_pkg::mrl_ctrl_t           ctrl_i,
  input  mrl_pkg::mrl_req_t            req_i,
  input  logic                         cfg_we_i,
  input  logic [mrl_pkg::CNT_W-1:0]    cfg_wdata_i,
  output mrl_pkg::mrl_res_t            res_o
);
  import mrl_pkg::*;

  logic [KEY_WIDTH-1:0] entries_q [DEPTH];
  logic [KEY_WIDTH-1:0] entries_d [DEPTH];
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     max_size_q;
  mrl_req_t             req_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     hit_pos_q;
  mrl_res_t             res_q, res_d;

  logic                 srch_hit;
  logic [IDX_W-1:0]     srch_pos;
  logic [CNT_W-1:0]     eff_max;
  logic [IDX_W-1:0]     rd_addr;
  logic [KEY_WIDTH-1:0] rd_key;
  logic                 do_shift;
  logic [IDX_W-1:0]     top;
  logic [KEY_WIDTH-1:0] front_key;
  logic                 evict;

  // Parallel match over the valid part of the list; lowest position wins.
  always_comb begin
    srch_hit = 1'b0;
    srch_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < cnt_q) && (entries_q[i] == req_i.key)) begin
        srch_hit = 1'b1;
        srch_pos = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (max_size_q == '0)                eff_max = CNT_W'(1);
    else if (max_size_q > CNT_W'(DEPTH)) eff_max = CNT_W'(DEPTH);
    else                                 eff_max = max_size_q;
  end

  assign evict = (cnt_q >= eff_max);

  always_comb begin
    if (req_q.cmd == CMD_PUT) begin
      rd_addr = hit_q ? hit_pos_q : IDX_W'(cnt_q - CNT_W'(1));
    end else begin
      rd_addr = req_q.index;
    end
  end

  assign rd_key = entries_q[rd_addr];

  always_comb begin
    res_d     = '0;
    cnt_d     = cnt_q;
    do_shift  = 1'b0;
    top       = '0;
    front_key = req_q.key;
    case (req_q.cmd)
      CMD_PUT: begin
        if (req_q.key == '0) begin
          res_d.status = STAT_NULL_KEY;
        end else if (hit_q) begin
          res_d.hit          = 1'b1;
          res_d.hit_position = hit_pos_q;
          do_shift           = 1'b1;
          top                = hit_pos_q;
        end else begin
          do_shift = 1'b1;
          if (evict) begin
            res_d.evicted     = 1'b1;
            res_d.evicted_key = rd_key;
            top               = IDX_W'(cnt_q - CNT_W'(1));
          end else begin
            top   = IDX_W'(cnt_q);
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      CMD_PROMOTE, CMD_LOOK: begin
        if (CNT_W'(req_q.index) >= cnt_q) begin
          res_d.status = STAT_RANGE;
        end else begin
          res_d.key_out = rd_key;
          if (req_q.cmd == CMD_PROMOTE) begin
            do_shift  = 1'b1;
            top       = req_q.index;
            front_key = rd_key;
          end
        end
      end
      default: res_d.status = STAT_OK;
    endcase
    res_d.count = cnt_d;
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_d[i] = entries_q[i];
    end
    if (ctrl_i.apply && do_shift) begin
      entries_d[0] = front_key;
      for (int i = 1; i < DEPTH; i++) begin
        if (IDX_W'(i) <= top) entries_d[i] = entries_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      entries_q[i] <= entries_d[i];
    end
    if (ctrl_i.capture) begin
      req_q     <= req_i;
      hit_q     <= srch_hit;
      hit_pos_q <= srch_pos;
    end
    if (ctrl_i.apply) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      max_size_q <= MAX_SIZE_RST;
    end else begin
      if (ctrl_i.apply) cnt_q <= cnt_d;
      if (cfg_we_i) max_size_q <= cfg_wdata_i;
    end
  end

  assign res_o = res_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH)) else $error("entry count above depth");
  a_count_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.apply |=> $stable(cnt_q)) else $error("entry count moved outside apply");
  a_put_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.apply && req_q.cmd == CMD_PUT && req_q.key != '0 |=> entries_q[0] == $past(req_q.key))
    else $error("put key not at front");
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.apply && res_d.evicted |-> !res_d.hit && cnt_d == cnt_q)
    else $error("eviction changed the entry count");

endmodule

`default_nettype wire
